FILE: src/shrad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shrad_pkg - shared types and constants for the SH order-2 evaluator
// Fixed-point widths, basis constants (Q.24) and the request control word.
// ----------------------------------------------------------------------------
package shrad_pkg;

  localparam int unsigned COEF_WIDTH_DEF   = 24;
  localparam int unsigned NORMAL_WIDTH_DEF = 16;

  localparam int unsigned NUM_SLOTS = 9;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned NUM_TERMS = 8;   // basis terms that need a multiply
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CH_W      = 2;

  localparam int unsigned FRAC    = 24;    // Q.24 fraction bits
  localparam int unsigned NQ_W    = 26;    // normal component widened to Q.24
  localparam int unsigned SQ_W    = 28;    // rounded square or cross product
  localparam int unsigned OPD_W   = 29;    // operand of the constant multiply
  localparam int unsigned K_W     = 26;    // basis constant
  localparam int unsigned PK_W    = K_W + OPD_W;
  localparam int unsigned RND_W   = PK_W + 1;
  localparam int unsigned BASIS_W = 28;
  localparam int unsigned OUT_W   = 32;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_RADIANCE   = 2'd1,
    OP_IRRADIANCE = 2'd2
  } op_e;

  typedef struct packed {
    logic              is_wr;
    logic              irr;
    logic [SLOT_W-1:0] slot;
    logic [CH_W-1:0]   ch;
  } item_ctl_t;

  typedef logic signed [BASIS_W-1:0] basis_t;
  typedef logic signed [K_W-1:0]     kq_t;

  // Six-decimal constants rounded to nearest Q.24
  localparam kq_t K_RAD_Y00 = kq_t'((64'sd282095  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_RAD_B1  = kq_t'((64'sd488603  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_RAD_B2X = kq_t'((64'sd1092548 * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_RAD_B20 = kq_t'((64'sd315392  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_RAD_B22 = kq_t'((64'sd546274  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_IRR_Y00 = kq_t'((64'sd886227  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_IRR_B1  = kq_t'((64'sd1023328 * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_IRR_B2X = kq_t'((64'sd858086  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_IRR_B20 = kq_t'((64'sd743125  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_IRR_OFS = kq_t'((64'sd247708  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam kq_t K_IRR_B22 = kq_t'((64'sd429043  * 64'sd16777216 + 64'sd500000) / 64'sd1000000);

  // Terms 1..8 in order: y, z, x, xy, yz, zz-term, xz, xx-yy
  localparam kq_t K_RAD [NUM_TERMS] = '{K_RAD_B1, K_RAD_B1, K_RAD_B1, K_RAD_B2X,
                                        K_RAD_B2X, K_RAD_B20, K_RAD_B2X, K_RAD_B22};
  localparam kq_t K_IRR [NUM_TERMS] = '{K_IRR_B1, K_IRR_B1, K_IRR_B1, K_IRR_B2X,
                                        K_IRR_B2X, K_IRR_B20, K_IRR_B2X, K_IRR_B22};

  localparam int unsigned TERM_ZZ = 5;

  localparam logic signed [RND_W-1:0] HALF_RND = RND_W'(64'sd1 <<< (FRAC - 1));
  // Fold the irradiance zz offset into the rounding constant
  localparam logic signed [RND_W-1:0] OFS_RND  = HALF_RND - (RND_W'(K_IRR_OFS) <<< FRAC);
  localparam logic signed [OPD_W-1:0] ONE_OPD  = OPD_W'(64'sd1 <<< FRAC);

endpackage
`default_nettype wire

FILE: src/shrad_basis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shrad_basis - normal to SH basis terms, five register stages
// Products, rounding, operand forming, constant multiply, final rounding.
// ----------------------------------------------------------------------------
module shrad_basis #(
  parameter int unsigned COEF_WIDTH   = shrad_pkg::COEF_WIDTH_DEF,
  parameter int unsigned NORMAL_WIDTH = shrad_pkg::NORMAL_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_vld_i,
  output logic                                in_rdy_o,
  input  wire shrad_pkg::item_ctl_t           in_ctl_i,
  input  wire logic signed [COEF_WIDTH-1:0]   in_wr_val_i,
  input  wire logic signed [NORMAL_WIDTH-1:0] nx_i,
  input  wire logic signed [NORMAL_WIDTH-1:0] ny_i,
  input  wire logic signed [NORMAL_WIDTH-1:0] nz_i,
  output logic                                out_vld_o,
  input  wire logic                           out_rdy_i,
  output shrad_pkg::item_ctl_t                out_ctl_o,
  output logic signed [COEF_WIDTH-1:0]        out_wr_val_o,
  output shrad_pkg::basis_t                   basis_o [shrad_pkg::NUM_SLOTS]
);

  localparam int unsigned NSTG = 5;
  localparam int unsigned NQ_W = shrad_pkg::NQ_W;
  localparam int unsigned P_W  = 2 * NQ_W;
  localparam int unsigned SQ_W = shrad_pkg::SQ_W;
  localparam int unsigned OPD_W = shrad_pkg::OPD_W;
  localparam int unsigned PK_W = shrad_pkg::PK_W;
  localparam int unsigned RND_W = shrad_pkg::RND_W;
  localparam int unsigned FRAC = shrad_pkg::FRAC;
  localparam int unsigned BASIS_W = shrad_pkg::BASIS_W;
  localparam int unsigned NT = shrad_pkg::NUM_TERMS;
  localparam logic signed [P_W-1:0] HALF_P = P_W'(64'sd1 <<< (FRAC - 1));

  logic [NSTG-1:0]               vld_q;
  logic [NSTG-1:0]               rdy;
  shrad_pkg::item_ctl_t          ctl_q [NSTG];
  logic signed [COEF_WIDTH-1:0]  wrv_q [NSTG];

  logic signed [NQ_W-1:0]  xw, yw, zw;
  logic signed [NQ_W-1:0]  x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic signed [P_W-1:0]   p1_d [6];
  logic signed [P_W-1:0]   p1_q [6];
  logic signed [P_W-1:0]   rs2  [6];
  logic signed [SQ_W-1:0]  sq2_d [6];
  logic signed [SQ_W-1:0]  sq2_q [6];
  logic signed [OPD_W-1:0] opd3_d [NT];
  logic signed [OPD_W-1:0] opd3_q [NT];
  logic signed [PK_W-1:0]  pk4_d [NT];
  logic signed [PK_W-1:0]  pk4_q [NT];
  logic signed [RND_W-1:0] rs5 [NT];
  shrad_pkg::basis_t       basis_d [shrad_pkg::NUM_SLOTS];
  shrad_pkg::basis_t       basis_q [shrad_pkg::NUM_SLOTS];

  // Ready chain: a stage takes a request when empty or when it moves on
  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_rdy_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_rdy_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_vld_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ctl_q[0] <= in_ctl_i;
      wrv_q[0] <= in_wr_val_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        ctl_q[k] <= ctl_q[k-1];
        wrv_q[k] <= wrv_q[k-1];
      end
    end
  end

  // Stage 1: widen to Q.24 and form the six products
  assign xw = $signed({nx_i, {(NQ_W - NORMAL_WIDTH){1'b0}}});
  assign yw = $signed({ny_i, {(NQ_W - NORMAL_WIDTH){1'b0}}});
  assign zw = $signed({nz_i, {(NQ_W - NORMAL_WIDTH){1'b0}}});

  always_comb begin
    p1_d[0] = xw * yw;
    p1_d[1] = yw * zw;
    p1_d[2] = xw * zw;
    p1_d[3] = xw * xw;
    p1_d[4] = yw * yw;
    p1_d[5] = zw * zw;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x1_q <= xw;
      y1_q <= yw;
      z1_q <= zw;
      p1_q <= p1_d;
    end
  end

  // Stage 2: round products to Q.24
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rs2[i]   = p1_q[i] + HALF_P;
      sq2_d[i] = rs2[i][FRAC +: SQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      z2_q  <= z1_q;
      sq2_q <= sq2_d;
    end
  end

  // Stage 3: operands of the constant multiply
  always_comb begin
    opd3_d[0] = OPD_W'(y2_q);
    opd3_d[1] = OPD_W'(z2_q);
    opd3_d[2] = OPD_W'(x2_q);
    opd3_d[3] = OPD_W'(sq2_q[0]);
    opd3_d[4] = OPD_W'(sq2_q[1]);
    if (ctl_q[1].irr) begin
      opd3_d[shrad_pkg::TERM_ZZ] = OPD_W'(sq2_q[5]);
    end else begin
      opd3_d[shrad_pkg::TERM_ZZ] = OPD_W'(sq2_q[5]) + (OPD_W'(sq2_q[5]) <<< 1)
                                 - shrad_pkg::ONE_OPD;
    end
    opd3_d[6] = OPD_W'(sq2_q[2]);
    opd3_d[7] = OPD_W'(sq2_q[3]) - OPD_W'(sq2_q[4]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      opd3_q <= opd3_d;
    end
  end

  // Stage 4: scale by the basis constant
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      if (ctl_q[2].irr) begin
        pk4_d[i] = shrad_pkg::K_IRR[i] * opd3_q[i];
      end else begin
        pk4_d[i] = shrad_pkg::K_RAD[i] * opd3_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      pk4_q <= pk4_d;
    end
  end

  // Stage 5: round to Q.24 basis terms
  always_comb begin
    basis_d[0] = ctl_q[3].irr ? BASIS_W'(shrad_pkg::K_IRR_Y00)
                              : BASIS_W'(shrad_pkg::K_RAD_Y00);
    for (int i = 0; i < NT; i++) begin
      if (ctl_q[3].irr && (i == shrad_pkg::TERM_ZZ)) begin
        rs5[i] = RND_W'(pk4_q[i]) + shrad_pkg::OFS_RND;
      end else begin
        rs5[i] = RND_W'(pk4_q[i]) + shrad_pkg::HALF_RND;
      end
      basis_d[i+1] = rs5[i][FRAC +: BASIS_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      basis_q <= basis_d;
    end
  end

  assign out_vld_o    = vld_q[NSTG-1];
  assign out_ctl_o    = ctl_q[NSTG-1];
  assign out_wr_val_o = wrv_q[NSTG-1];
  assign basis_o      = basis_q;

endmodule
`default_nettype wire

FILE: src/shrad_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shrad_mac - coefficient store and coefficient-times-basis products
// Applies writes in request order and forms 27 products per evaluation.
// ----------------------------------------------------------------------------
module shrad_mac #(
  parameter int unsigned COEF_WIDTH = shrad_pkg::COEF_WIDTH_DEF,
  localparam int unsigned PROD_W    = COEF_WIDTH + shrad_pkg::BASIS_W
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_vld_i,
  output logic                              in_rdy_o,
  input  wire shrad_pkg::item_ctl_t         in_ctl_i,
  input  wire logic signed [COEF_WIDTH-1:0] in_wr_val_i,
  input  wire shrad_pkg::basis_t            basis_i [shrad_pkg::NUM_SLOTS],
  output logic                              out_vld_o,
  input  wire logic                         out_rdy_i,
  output logic signed [PROD_W-1:0]          prod_o [shrad_pkg::NUM_CH][shrad_pkg::NUM_SLOTS]
);

  localparam int unsigned NS = shrad_pkg::NUM_SLOTS;
  localparam int unsigned NC = shrad_pkg::NUM_CH;

  logic                         vld_q;
  logic                         take;
  logic signed [COEF_WIDTH-1:0] coef_q [NS][NC];
  logic signed [PROD_W-1:0]     prod_q [NC][NS];

  assign in_rdy_o = !vld_q || out_rdy_i;
  assign take     = in_vld_i && in_rdy_o;

  // Writes land here, so evaluations ahead of a write see the old value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) begin
        for (int c = 0; c < NC; c++) begin
          coef_q[s][c] <= '0;
        end
      end
    end else if (take && in_ctl_i.is_wr) begin
      for (int s = 0; s < NS; s++) begin
        for (int c = 0; c < NC; c++) begin
          if ((in_ctl_i.slot == shrad_pkg::SLOT_W'(s)) &&
              (in_ctl_i.ch == shrad_pkg::CH_W'(c))) begin
            coef_q[s][c] <= in_wr_val_i;
          end
        end
      end
    end
  end

  // Drop write requests once applied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_rdy_o) begin
      vld_q <= in_vld_i && !in_ctl_i.is_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o) begin
      for (int c = 0; c < NC; c++) begin
        for (int s = 0; s < NS; s++) begin
          prod_q[c][s] <= coef_q[s][c] * basis_i[s];
        end
      end
    end
  end

  assign out_vld_o = vld_q;
  assign prod_o    = prod_q;

endmodule
`default_nettype wire

FILE: src/shrad_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shrad_reduce - per-channel sum of nine products, round and saturate
// Registered adder tree 9-5-3-2-1, then Q.16 rounding and 32-bit clamp.
// ----------------------------------------------------------------------------
module shrad_reduce #(
  parameter int unsigned COEF_WIDTH = shrad_pkg::COEF_WIDTH_DEF,
  localparam int unsigned PROD_W    = COEF_WIDTH + shrad_pkg::BASIS_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_vld_i,
  output logic                          in_rdy_o,
  input  wire logic signed [PROD_W-1:0] prod_i [shrad_pkg::NUM_CH][shrad_pkg::NUM_SLOTS],
  output logic                          out_vld_o,
  input  wire logic                     out_rdy_i,
  output logic [shrad_pkg::OUT_W-1:0]   res_o [shrad_pkg::NUM_CH]
);

  localparam int unsigned NSTG  = 5;
  localparam int unsigned NC    = shrad_pkg::NUM_CH;
  localparam int unsigned OUT_W = shrad_pkg::OUT_W;
  localparam int unsigned FRAC  = shrad_pkg::FRAC;
  localparam int unsigned ACC_W = PROD_W + 4;
  localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-64'sd2147483648);

  logic [NSTG-1:0]         vld_q;
  logic [NSTG-1:0]         rdy;
  logic signed [ACC_W-1:0] t1_q [NC][5];
  logic signed [ACC_W-1:0] t2_q [NC][3];
  logic signed [ACC_W-1:0] t3_q [NC][2];
  logic signed [ACC_W-1:0] t4_q [NC];
  logic signed [ACC_W-1:0] rnd  [NC];
  logic signed [ACC_W-1:0] shr  [NC];
  logic [OUT_W-1:0]        res_d [NC];
  logic [OUT_W-1:0]        res_q [NC];

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_rdy_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_rdy_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_vld_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NC; c++) begin
      if (rdy[0]) begin
        for (int i = 0; i < 4; i++) begin
          t1_q[c][i] <= ACC_W'(prod_i[c][2*i]) + ACC_W'(prod_i[c][2*i+1]);
        end
        t1_q[c][4] <= ACC_W'(prod_i[c][8]);
      end
      if (rdy[1]) begin
        t2_q[c][0] <= t1_q[c][0] + t1_q[c][1];
        t2_q[c][1] <= t1_q[c][2] + t1_q[c][3];
        t2_q[c][2] <= t1_q[c][4];
      end
      if (rdy[2]) begin
        t3_q[c][0] <= t2_q[c][0] + t2_q[c][1];
        t3_q[c][1] <= t2_q[c][2];
      end
      if (rdy[3]) begin
        t4_q[c] <= t3_q[c][0] + t3_q[c][1];
      end
      if (rdy[4]) begin
        res_q[c] <= res_d[c];
      end
    end
  end

  // Round Q.40 to Q.16, clamp to the 32-bit range
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      rnd[c] = t4_q[c] + HALF_ACC;
      shr[c] = rnd[c] >>> FRAC;
      priority if (shr[c] > SAT_HI) begin
        res_d[c] = SAT_HI[OUT_W-1:0];
      end else if (shr[c] < SAT_LO) begin
        res_d[c] = SAT_LO[OUT_W-1:0];
      end else begin
        res_d[c] = shr[c][OUT_W-1:0];
      end
    end
  end

  assign out_vld_o = vld_q[NSTG-1];
  assign res_o     = res_q;

endmodule
`default_nettype wire

FILE: src/sh_order2_radiance_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sh_order2_radiance_eval - order-2 spherical harmonic radiance/irradiance
// Nine RGB coefficients; each normal request returns a saturated RGB sum.
// ----------------------------------------------------------------------------
//  channel  dir  signals                         contents
//  s_axis   in   tvalid tready tdata[79:0]      operation, slot, channel,
//                                                coefficient, normal x y z
//  m_axis   out  tvalid tready tdata[95:0]      red, green, blue (Q15.16)
//
//  One request per cycle is taken when the output side keeps up.
//  An evaluation passes five basis stages, one coefficient multiply stage,
//  four adder-tree stages and one clamp stage.
//  A coefficient write updates the store at the multiply stage, in request
//  order with evaluations. Reset clears the store and all valid bits.
//  A stall fills empty stages first; no request is lost or repeated.
// ----------------------------------------------------------------------------
module sh_order2_radiance_eval #(
  parameter int unsigned  COEF_WIDTH   = shrad_pkg::COEF_WIDTH_DEF,
  parameter int unsigned  NORMAL_WIDTH = shrad_pkg::NORMAL_WIDTH_DEF,
  localparam int unsigned S_TDATA_W    = ((8 + COEF_WIDTH + 3 * NORMAL_WIDTH + 7) / 8) * 8,
  localparam int unsigned M_TDATA_W    = 3 * shrad_pkg::OUT_W,
  localparam int unsigned PROD_W       = COEF_WIDTH + shrad_pkg::BASIS_W
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // operation[1:0], coef_slot[5:2], coef_channel[7:6], coef_value,
  // normal_x, normal_y, normal_z, zero fill
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // red_out[31:0], green_out[63:32], blue_out[95:64]
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned VAL_LO = 8;
  localparam int unsigned NX_LO  = VAL_LO + COEF_WIDTH;
  localparam int unsigned NY_LO  = NX_LO + NORMAL_WIDTH;
  localparam int unsigned NZ_LO  = NY_LO + NORMAL_WIDTH;

  shrad_pkg::op_e                     op;
  logic [shrad_pkg::SLOT_W-1:0]       slot;
  logic [shrad_pkg::CH_W-1:0]         ch;
  logic signed [COEF_WIDTH-1:0]       coef_value;
  logic signed [NORMAL_WIDTH-1:0]     normal_x, normal_y, normal_z;
  logic                               wr_ok, is_eval, in_vld;
  shrad_pkg::item_ctl_t               in_ctl;

  logic                               bas_vld, bas_rdy;
  shrad_pkg::item_ctl_t               bas_ctl;
  logic signed [COEF_WIDTH-1:0]       bas_wr_val;
  shrad_pkg::basis_t                  bas_basis [shrad_pkg::NUM_SLOTS];

  logic                               mac_vld, mac_rdy;
  logic signed [PROD_W-1:0]           mac_prod [shrad_pkg::NUM_CH][shrad_pkg::NUM_SLOTS];

  logic [shrad_pkg::OUT_W-1:0]        res [shrad_pkg::NUM_CH];

  assign op         = shrad_pkg::op_e'(s_axis_tdata[1:0]);
  assign slot       = s_axis_tdata[5:2];
  assign ch         = s_axis_tdata[7:6];
  assign coef_value = s_axis_tdata[VAL_LO +: COEF_WIDTH];
  assign normal_x   = s_axis_tdata[NX_LO +: NORMAL_WIDTH];
  assign normal_y   = s_axis_tdata[NY_LO +: NORMAL_WIDTH];
  assign normal_z   = s_axis_tdata[NZ_LO +: NORMAL_WIDTH];

  // Take bad writes and the unused operation, but drop them at the door
  assign wr_ok   = (op == shrad_pkg::OP_WRITE) &&
                   (slot < shrad_pkg::SLOT_W'(shrad_pkg::NUM_SLOTS)) &&
                   (ch < shrad_pkg::CH_W'(shrad_pkg::NUM_CH));
  assign is_eval = (op == shrad_pkg::OP_RADIANCE) || (op == shrad_pkg::OP_IRRADIANCE);
  assign in_vld  = s_axis_tvalid && (wr_ok || is_eval);

  always_comb begin
    in_ctl.is_wr = (op == shrad_pkg::OP_WRITE);
    in_ctl.irr   = (op == shrad_pkg::OP_IRRADIANCE);
    in_ctl.slot  = slot;
    in_ctl.ch    = ch;
  end

  shrad_basis #(
    .COEF_WIDTH   (COEF_WIDTH),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_basis (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (in_vld),
    .in_rdy_o     (s_axis_tready),
    .in_ctl_i     (in_ctl),
    .in_wr_val_i  (coef_value),
    .nx_i         (normal_x),
    .ny_i         (normal_y),
    .nz_i         (normal_z),
    .out_vld_o    (bas_vld),
    .out_rdy_i    (bas_rdy),
    .out_ctl_o    (bas_ctl),
    .out_wr_val_o (bas_wr_val),
    .basis_o      (bas_basis)
  );

  shrad_mac #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (bas_vld),
    .in_rdy_o    (bas_rdy),
    .in_ctl_i    (bas_ctl),
    .in_wr_val_i (bas_wr_val),
    .basis_i     (bas_basis),
    .out_vld_o   (mac_vld),
    .out_rdy_i   (mac_rdy),
    .prod_o      (mac_prod)
  );

  shrad_reduce #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (mac_vld),
    .in_rdy_o  (mac_rdy),
    .prod_i    (mac_prod),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .res_o     (res)
  );

  assign m_axis_tdata = {res[2], res[1], res[0]};

`ifndef SYNTHESIS
  // A taking output side leaves the whole pipeline able to move
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side takes results");

  // Input backs up only when every stage is full up to a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // Only filtered writes reach the coefficient store
  a_store_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bas_vld && bas_rdy && bas_ctl.is_wr) |->
      ((bas_ctl.slot < shrad_pkg::SLOT_W'(shrad_pkg::NUM_SLOTS)) &&
       (bas_ctl.ch < shrad_pkg::CH_W'(shrad_pkg::NUM_CH))))
    else $error("write to a nonexistent coefficient");
`endif

endmodule
`default_nettype wire
